// ===== rtl/otsb_pkg.sv =====
// ----------------------------------------------------------------------------
// otsb_pkg: shared types for the one-shot timer bank
// Item kinds, the per-slot memory entry and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

package otsb_pkg;

    // item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;
    localparam logic [1:0] KIND_QUERY = 2'd3;

    localparam int MASK_W = 8;

    // one slot as held in memory
    typedef struct packed {
        logic        running;
        logic        fired;
        logic [31:0] elapsed;
        logic [31:0] target;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // result word handed from the sequencer to the output register
    typedef struct packed {
        logic              slot_fired;
        logic              slot_running;
        logic [31:0]       system_time;
        logic [MASK_W-1:0] fired_now_mask;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/otsb_if.sv =====
// ----------------------------------------------------------------------------
// otsb_in_if / otsb_out_if: valid/ready channels of the timer bank
// Command words in, status words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface otsb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic [31:0] duration;

    modport source (output valid, kind, slot, duration, input ready);
    modport sink   (input valid, kind, slot, duration, output ready);
endinterface

interface otsb_out_if;
    logic        valid;
    logic        ready;
    logic        slot_fired;
    logic        slot_running;
    logic [31:0] system_time;
    logic [7:0]  fired_now_mask;

    modport source (output valid, slot_fired, slot_running, system_time, fired_now_mask,
                    input ready);
    modport sink   (input valid, slot_fired, slot_running, system_time, fired_now_mask,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/otsb_ram.sv =====
// ----------------------------------------------------------------------------
// otsb_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module otsb_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/otsb_ctrl.sv =====
// ----------------------------------------------------------------------------
// otsb_ctrl: command sequencer of the timer bank
// Decodes a command word and runs read-modify-write passes over the slot RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module otsb_ctrl import otsb_pkg::*; #(
    parameter  int SLOTS = 8,
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    otsb_in_if.sink     i_in,
    output logic        o_res_valid,
    output t_result     o_res,
    input  wire logic   i_res_ready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_QRY  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        r_state,    n_state;
    logic [SLOTS-1:0]  r_vld,      n_vld;
    logic [31:0]       r_time,     n_time;
    logic [MASK_W-1:0] r_mask,     n_mask;
    logic              r_sf,       n_sf;
    logic              r_sr,       n_sr;
    logic [AW-1:0]     r_rd_idx,   n_rd_idx;
    logic [AW-1:0]     r_slot_idx, n_slot_idx;
    logic              r_slot_ok,  n_slot_ok;

    logic              in_acc;
    logic              slot_ok;
    logic [AW-1:0]     slot_idx;
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    t_entry            ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry            rd_ent, upd_ent;
    logic [31:0]       elapsed_inc;
    logic              hit;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign slot_ok    = (32'(i_in.slot) < 32'(SLOTS));
    assign slot_idx   = AW'(i_in.slot);

    // slot state memory
    otsb_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // never-written entries read as the reset value
    assign rd_ent = r_vld[r_rd_idx] ? t_entry'(ram_rdata) : '0;

    // tick update of one slot
    assign elapsed_inc = rd_ent.elapsed + 32'd1;
    assign hit         = rd_ent.running && (elapsed_inc >= rd_ent.target);

    always_comb begin
        upd_ent = rd_ent;
        if (rd_ent.running) begin
            upd_ent.elapsed = elapsed_inc;
            if (hit) begin
                upd_ent.running = 1'b0;
                upd_ent.fired   = 1'b1;
                upd_ent.elapsed = '0;
            end
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_vld      = r_vld;
        n_time     = r_time;
        n_mask     = r_mask;
        n_sf       = r_sf;
        n_sr       = r_sr;
        n_rd_idx   = r_rd_idx;
        n_slot_idx = r_slot_idx;
        n_slot_ok  = r_slot_ok;
        ram_we     = 1'b0;
        ram_waddr  = slot_idx;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = slot_idx;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_slot_idx = slot_idx;
                    n_slot_ok  = slot_ok;
                    n_mask     = '0;
                    n_sf       = 1'b0;
                    n_sr       = 1'b0;
                    unique case (i_in.kind)
                        KIND_TICK: begin
                            n_time    = r_time + 32'd1;
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_rd_idx  = '0;
                            n_state   = S_WALK;
                        end
                        KIND_START: begin
                            if (slot_ok) begin
                                ram_we            = 1'b1;
                                ram_wdata.running = 1'b1;
                                ram_wdata.target  = i_in.duration;
                                n_vld[slot_idx]   = 1'b1;
                                n_sr              = 1'b1;
                            end
                            n_state = S_DONE;
                        end
                        KIND_STOP: begin
                            // a stopped slot's count and target are dead until restart
                            if (slot_ok) begin
                                ram_we          = 1'b1;
                                n_vld[slot_idx] = 1'b1;
                            end
                            n_state = S_DONE;
                        end
                        KIND_QUERY: begin
                            ram_re   = 1'b1;
                            n_rd_idx = slot_idx;
                            n_state  = S_QRY;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_WALK: begin
                // write back slot r_rd_idx if it is running, fetch the next one unless it is the last
                if (rd_ent.running) begin
                    ram_we             = 1'b1;
                    ram_waddr          = r_rd_idx;
                    ram_wdata          = upd_ent;
                    n_vld[r_rd_idx]    = 1'b1;
                end
                for (int k = 0; k < MASK_W; k++) begin
                    if (hit && (32'(r_rd_idx) == k)) begin
                        n_mask[k] = 1'b1;
                    end
                end
                if (r_slot_ok && (r_rd_idx == r_slot_idx)) begin
                    n_sf = upd_ent.fired;
                    n_sr = upd_ent.running;
                end
                if (r_rd_idx == AW'(SLOTS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_rd_idx + AW'(1);
                    n_rd_idx  = r_rd_idx + AW'(1);
                end
            end
            S_QRY: begin
                n_sf    = r_slot_ok && rd_ent.fired;
                n_sr    = r_slot_ok && rd_ent.running;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
            r_time  <= '0;
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
            r_time  <= n_time;
        end
        r_mask     <= n_mask;
        r_sf       <= n_sf;
        r_sr       <= n_sr;
        r_rd_idx   <= n_rd_idx;
        r_slot_idx <= n_slot_idx;
        r_slot_ok  <= n_slot_ok;
    end

    assign o_res_valid          = (r_state == S_DONE);
    assign o_res.slot_fired     = r_sf;
    assign o_res.slot_running   = r_sr;
    assign o_res.system_time    = r_time;
    assign o_res.fired_now_mask = r_mask;

endmodule

`default_nettype wire

// ===== rtl/one_shot_timer_bank_unit.sv =====
// ----------------------------------------------------------------------------
// one_shot_timer_bank_unit: bank of SLOTS one-shot event timers
//
// Command words enter on i_in (kind, slot, duration); every command gives
// exactly one status word on o_out (named slot's fired and running flags,
// system time, and the mask of slots that expired on this tick).
// Slot state (running, fired, count, target) sits in one RAM with a
// registered read; the sequencer handles one command at a time.
// A tick walks the whole bank, one slot per cycle, reading the next slot
// while writing back the current one if it is running. Every status word
// waits in the sequencer's done state until the output register takes it,
// and only then does the sequencer accept the next command.
// Reset clears the sequencer, the system time and the per-slot written
// bits, so every slot reads as idle with zero count straight away; no
// clearing pass is needed.
// When the receiver stalls, the status word waits in the output register
// while the next command is still taken and processed; its own result then
// waits in the sequencer until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module one_shot_timer_bank_unit import otsb_pkg::*; #(
    parameter int SLOTS = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    otsb_in_if.sink   i_in,
    otsb_out_if.source o_out
);

    logic    res_valid;
    logic    res_ready;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    otsb_ctrl #(.SLOTS(SLOTS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // output register
    assign res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.slot_fired     = r_out.slot_fired;
    assign o_out.slot_running   = r_out.slot_running;
    assign o_out.system_time    = r_out.system_time;
    assign o_out.fired_now_mask = r_out.fired_now_mask;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the one-shot timer bank
// Tick, start, stop and query words go in through the command channel.
// A local timer bank model predicts every status word. A checker process
// compares each returned word field by field, in order. Both channels idle
// at random, and one long receiver hold-off fills the block and stalls it.
// ----------------------------------------------------------------------------

module tb_top import otsb_pkg::*; ();

    localparam int SLOTS    = 8;
    localparam int MAX_IDLE = 8;

    logic i_clk;
    logic i_rst_n;

    otsb_in_if  in_if ();
    otsb_out_if out_if ();

    one_shot_timer_bank_unit #(.SLOTS(SLOTS)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // timer bank model state
    bit          slot_running [SLOTS];
    bit          slot_fired   [SLOTS];
    logic [31:0] slot_count   [SLOTS];
    logic [31:0] slot_target  [SLOTS];
    logic [31:0] tick_count;

    t_result status_due [$];      // status words still to come, oldest first
    int      mismatches;

    // idling controls; rx_idle and the hold-off are shared with the receiver process
    bit tx_idle;
    bit rx_idle;
    int tx_gap;                   // cycles to hold off before the next word
    bit hold_req;
    int hold_len;

    // Apply one command to the model and return the status word it gives
    function automatic t_result predict_status(input logic [1:0]  kind,
                                               input logic [2:0]  slot,
                                               input logic [31:0] duration);
        t_result r;
        logic [MASK_W-1:0] expired;
        expired = '0;
        case (kind)
            KIND_TICK: begin
                tick_count = tick_count + 32'd1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_running[i]) begin
                        slot_count[i] = slot_count[i] + 32'd1;
                        if (slot_count[i] >= slot_target[i]) begin
                            slot_running[i] = 1'b0;
                            slot_fired[i]   = 1'b1;
                            slot_count[i]   = '0;
                            if (i < MASK_W) expired[i] = 1'b1;
                        end
                    end
                end
            end
            KIND_START: begin
                if (slot < SLOTS) begin
                    slot_running[slot] = 1'b1;
                    slot_fired[slot]   = 1'b0;
                    slot_count[slot]   = '0;
                    slot_target[slot]  = duration;
                end
            end
            KIND_STOP: begin
                if (slot < SLOTS) begin
                    slot_running[slot] = 1'b0;
                    slot_fired[slot]   = 1'b0;
                end
            end
            default: ;
        endcase
        r.slot_fired     = (slot < SLOTS) ? slot_fired[slot] : 1'b0;
        r.slot_running   = (slot < SLOTS) ? slot_running[slot] : 1'b0;
        r.system_time    = tick_count;
        r.fired_now_mask = expired;
        return r;
    endfunction

    // Offer one command word and wait for the block to take it
    task automatic send_word(input logic [1:0]  kind,
                             input logic [2:0]  slot,
                             input logic [31:0] duration);
        repeat (tx_gap) @(posedge i_clk);
        in_if.valid    <= 1'b1;
        in_if.kind     <= kind;
        in_if.slot     <= slot;
        in_if.duration <= duration;
        do @(posedge i_clk); while (!in_if.ready);
        status_due.push_back(predict_status(kind, slot, duration));
        // gap before the next word; valid drops now only if there is one
        tx_gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (tx_gap > 0) in_if.valid <= 1'b0;
    endtask

    // Stop offering and wait until every status word has come back
    task automatic wait_drained();
        if (tx_gap == 0) in_if.valid <= 1'b0;
        do @(posedge i_clk); while (status_due.size() != 0);
        tx_gap = 0;
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Receiver: checks each status word, stalls at random or on a hold-off
    initial begin : status_checker
        int      wait_left;
        t_result want;
        wait_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                if (status_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: status word with none expected, actual fired %0b",
                             $time, out_if.slot_fired);
                end else begin
                    want = status_due.pop_front();
                    report_field("slot_fired", 32'(want.slot_fired),
                                 32'(out_if.slot_fired));
                    report_field("slot_running", 32'(want.slot_running),
                                 32'(out_if.slot_running));
                    report_field("system_time", want.system_time, out_if.system_time);
                    report_field("fired_now_mask", 32'(want.fired_now_mask),
                                 32'(out_if.fired_now_mask));
                end
                wait_left = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
            end else if (wait_left > 0) begin
                wait_left--;
            end
            if (hold_req) begin
                wait_left = hold_len;
                hold_req  = 1'b0;
            end
            out_if.ready <= (wait_left == 0);
        end
    end

    // Idle bank: a query and a tick that fires nothing
    task automatic test_reset_query();
        send_word(KIND_QUERY, 3'd0, 32'h0);
        send_word(KIND_TICK, 3'd7, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    // Target of zero fires on the first tick
    task automatic test_zero_target();
        send_word(KIND_START, 3'd0, 32'h0);
        send_word(KIND_TICK, 3'd0, 32'h0);
        wait_drained();
    endtask

    // Largest and smallest durations side by side
    task automatic test_extremes();
        send_word(KIND_START, 3'd7, 32'hFFFF_FFFF);
        send_word(KIND_START, 3'd1, 32'd1);
        send_word(KIND_START, 3'd2, 32'd2);
        send_word(KIND_TICK, 3'd1, 32'h0);
        send_word(KIND_TICK, 3'd2, 32'h0);
        wait_drained();
    endtask

    // Stop on running, fired and idle slots; restart of a running slot
    task automatic test_stop_restart();
        send_word(KIND_STOP, 3'd7, 32'h0);
        send_word(KIND_STOP, 3'd1, 32'h0);
        send_word(KIND_STOP, 3'd3, 32'h0);
        send_word(KIND_START, 3'd4, 32'd3);
        send_word(KIND_TICK, 3'd4, 32'h0);
        send_word(KIND_START, 3'd4, 32'd1);
        send_word(KIND_TICK, 3'd4, 32'h0);
        wait_drained();
    endtask

    // Every slot expires on the same tick
    task automatic test_all_fire();
        for (int i = 0; i < SLOTS; i++) send_word(KIND_START, 3'(i), 32'd1);
        send_word(KIND_TICK, 3'd5, 32'h0);
        wait_drained();
    endtask

    // Long receiver hold-off while the sender keeps offering back to back
    task automatic test_backpressure();
        tx_idle  = 1'b0;
        hold_len = 80;
        hold_req = 1'b1;
        send_word(KIND_START, 3'd6, 32'd2);
        for (int i = 0; i < 15; i++)
            send_word((i % 3 == 2) ? KIND_QUERY : KIND_TICK, 3'(i), $urandom);
        tx_idle = 1'b1;
        wait_drained();
    endtask

    // Random mix, mostly short timers so that slots keep expiring
    task automatic test_random(input int batches);
        int          pick;
        logic [1:0]  kind;
        logic [31:0] duration;
        for (int b = 0; b < batches; b++) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 50; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45)      kind = KIND_TICK;
                else if (pick < 70) kind = KIND_START;
                else if (pick < 80) kind = KIND_STOP;
                else                kind = KIND_QUERY;
                pick = $urandom_range(0, 9);
                if (pick < 7)       duration = $urandom_range(0, 12);
                else if (pick < 8)  duration = $urandom_range(13, 300);
                else                duration = $urandom;
                send_word(kind, 3'($urandom_range(0, 7)), duration);
            end
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        wait_drained();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.kind      <= KIND_QUERY;
        in_if.slot      <= '0;
        in_if.duration  <= '0;
        out_if.ready    <= 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_running[i] = 1'b0;
            slot_fired[i]   = 1'b0;
            slot_count[i]   = '0;
            slot_target[i]  = '0;
        end
        tick_count = '0;
        mismatches = 0;
        tx_idle    = 1'b1;
        rx_idle    = 1'b1;
        tx_gap     = 0;
        hold_req   = 1'b0;
        hold_len   = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_query();
        test_zero_target();
        test_extremes();
        test_stop_restart();
        test_all_fire();
        test_backpressure();
        test_random(10);

        // let any stray word surface before the verdict
        repeat (SLOTS + 10) @(posedge i_clk);
        if (mismatches == 0 && status_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
